// ===== design/lr_pkg.sv =====
// shared types, widths and register codes for the line rasterizer
// no dependencies; used by lr_ctrl, lr_datapath and line_rasterizer
`default_nettype none

package lr_pkg;

    localparam int MAX_SIDE    = 64;
    localparam int COORD_W     = 6;
    localparam int COLOR_W     = 24;
    localparam int FRAME_W     = 7;
    localparam int INC_W       = COORD_W + 1;
    localparam int ERR_W       = COORD_W + 3;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [FRAME_W-1:0] FRAME_RESET = 7'd64;

    typedef struct packed {
        logic load;
        logic step;
    } lr_cmd_t;

    typedef struct packed {
        logic last;
        logic out_valid;
    } lr_status_t;

    // saturate a coordinate to the largest supported coordinate, MAX_SIDE - 1
    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] c;
        c = v;
        if (int'(v) > MAX_SIDE - 1)
        begin
            c = COORD_W'(MAX_SIDE - 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/line_rasterizer.sv =====
// Line rasterizer: takes one segment (two 6-bit endpoints and a 24-bit color) and
// emits its pixels in Bresenham order, one pixel per cycle while the output is
// not stalled, each tagged with a visible flag against the frame size registers
// and a last_pixel marker on the final one. A segment of major length d produces
// d+1 pixels: the segment is loaded in a setup step, then each pixel comes from
// the single stepping unit; no new segment is taken until the last pixel is
// produced, and one is taken the cycle after that, even while that pixel still
// waits in the output register. Registers: index 0 frame_width, index 1
// frame_height (7 bits, reset 64); other indexes are ignored.
// Depends on lr_pkg, lr_ctrl and lr_datapath.
`default_nettype none

module line_rasterizer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [lr_pkg::COORD_W-1:0]     start_x,
    input  wire logic [lr_pkg::COORD_W-1:0]     start_y,
    input  wire logic [lr_pkg::COORD_W-1:0]     end_x,
    input  wire logic [lr_pkg::COORD_W-1:0]     end_y,
    input  wire logic [lr_pkg::COLOR_W-1:0]     line_color,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [lr_pkg::COORD_W-1:0]          pixel_x,
    output logic [lr_pkg::COORD_W-1:0]          pixel_y,
    output logic [lr_pkg::COLOR_W-1:0]          pixel_color,
    output logic                                visible,
    output logic                                last_pixel,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lr_pkg::FRAME_W-1:0]     cfg_data
);

    lr_pkg::lr_cmd_t    cmd;
    lr_pkg::lr_status_t status;

    assign cfg_ready = 1'b1;

    lr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .line_color  (line_color),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .visible     (visible),
        .last_pixel  (last_pixel)
    );

endmodule

`default_nettype wire

// ===== design/lr_ctrl.sv =====
// line rasterizer controller: accepts a segment, then steps the datapath once
// per free output slot until the last pixel; depends on lr_pkg
`default_nettype none

module lr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               out_stall,
    input  wire lr_pkg::lr_status_t status,
    output lr_pkg::lr_cmd_t         cmd
);

    typedef enum logic {
        IDLE,
        RUN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd.load   = (state_reg == IDLE) && in_valid;
        // output slot is free or its item leaves this cycle
        cmd.step   = (state_reg == RUN) && (!status.out_valid || !out_stall);
        in_stall   = (state_reg != IDLE);
        state_next = state_reg;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    state_next = RUN;
                end
            end
            RUN:
            begin
                if (cmd.step && status.last)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_last_ends_segment: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && status.last |=> !in_stall)
        else $error("segment did not end after its last pixel");

    a_no_step_into_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !(status.out_valid && out_stall))
        else $error("step while output slot held");
`endif

endmodule

`default_nettype wire

// ===== design/lr_datapath.sv =====
// line rasterizer datapath: segment setup, bresenham stepping registers,
// frame size registers and the output register; depends on lr_pkg
`default_nettype none

module lr_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lr_pkg::lr_cmd_t                   cmd,
    output lr_pkg::lr_status_t                     status,
    input  wire logic                              cfg_write,
    input  wire logic [lr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [lr_pkg::FRAME_W-1:0]        cfg_data,
    input  wire logic [lr_pkg::COORD_W-1:0]        start_x,
    input  wire logic [lr_pkg::COORD_W-1:0]        start_y,
    input  wire logic [lr_pkg::COORD_W-1:0]        end_x,
    input  wire logic [lr_pkg::COORD_W-1:0]        end_y,
    input  wire logic [lr_pkg::COLOR_W-1:0]        line_color,
    input  wire logic                              out_stall,
    output logic                                   out_valid,
    output logic [lr_pkg::COORD_W-1:0]             pixel_x,
    output logic [lr_pkg::COORD_W-1:0]             pixel_y,
    output logic [lr_pkg::COLOR_W-1:0]             pixel_color,
    output logic                                   visible,
    output logic                                   last_pixel
);

    localparam int CW = lr_pkg::COORD_W;
    localparam int EW = lr_pkg::ERR_W;

    logic [lr_pkg::FRAME_W-1:0] frame_width_reg;
    logic [lr_pkg::FRAME_W-1:0] frame_height_reg;

    // segment setup
    logic [CW-1:0] ax, ay, bx, by;
    logic [CW-1:0] adx, ady;
    logic          steep;
    logic [CW-1:0] mja, mna, mjb, mnb;
    logic [CW-1:0] s_major, s_minor, s_end;
    logic [CW-1:0] s_minor_end;
    logic [CW-1:0] s_dmin;

    // stepping state
    logic [CW-1:0]            major_reg, minor_reg, end_reg, dmaj_reg;
    logic [lr_pkg::INC_W-1:0] inc_reg;
    logic signed [EW-1:0]     err_reg;
    logic                     up_reg;
    logic                     steep_reg;
    logic [lr_pkg::COLOR_W-1:0] color_reg;

    logic signed [EW-1:0] err_sum;
    logic signed [EW-1:0] dmaj_s;
    logic signed [EW-1:0] dmaj2_s;
    logic [CW-1:0]        px, py;

    logic                       out_valid_reg;
    logic [CW-1:0]              pixel_x_reg, pixel_y_reg;
    logic [lr_pkg::COLOR_W-1:0] pixel_color_reg;
    logic                       visible_reg, last_pixel_reg;

    always_comb
    begin
        ax  = lr_pkg::clamp_coord(start_x);
        ay  = lr_pkg::clamp_coord(start_y);
        bx  = lr_pkg::clamp_coord(end_x);
        by  = lr_pkg::clamp_coord(end_y);
        adx = (ax >= bx) ? ax - bx : bx - ax;
        ady = (ay >= by) ? ay - by : by - ay;
        // equal slopes count as shallow
        steep = (adx < ady);
        mja   = steep ? ay : ax;
        mna   = steep ? ax : ay;
        mjb   = steep ? by : bx;
        mnb   = steep ? bx : by;
        if (mja > mjb)
        begin
            s_major     = mjb;
            s_minor     = mnb;
            s_end       = mja;
            s_minor_end = mna;
        end
        else
        begin
            s_major     = mja;
            s_minor     = mna;
            s_end       = mjb;
            s_minor_end = mnb;
        end
        s_dmin = (s_minor_end >= s_minor) ? s_minor_end - s_minor : s_minor - s_minor_end;
    end

    always_comb
    begin
        err_sum = err_reg + $signed({{(EW - lr_pkg::INC_W){1'b0}}, inc_reg});
        dmaj_s  = $signed({{(EW - CW){1'b0}}, dmaj_reg});
        dmaj2_s = $signed({{(EW - CW - 1){1'b0}}, dmaj_reg, 1'b0});
        px      = steep_reg ? minor_reg : major_reg;
        py      = steep_reg ? major_reg : minor_reg;
        status.last      = (major_reg == end_reg);
        status.out_valid = out_valid_reg;
    end

    // frame size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= lr_pkg::FRAME_RESET;
            frame_height_reg <= lr_pkg::FRAME_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lr_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                lr_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg  <= '0;
            dmaj_reg <= '0;
        end
        else if (cmd.load)
        begin
            err_reg  <= '0;
            dmaj_reg <= s_end - s_major;
        end
        else if (cmd.step)
        begin
            err_reg <= (err_sum > dmaj_s) ? err_sum - dmaj2_s : err_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            major_reg <= s_major;
            minor_reg <= s_minor;
            end_reg   <= s_end;
            inc_reg   <= {s_dmin, 1'b0};
            up_reg    <= (s_minor_end > s_minor);
            steep_reg <= steep;
            color_reg <= line_color;
        end
        else if (cmd.step)
        begin
            major_reg <= major_reg + 1'b1;
            if (err_sum > dmaj_s)
            begin
                minor_reg <= up_reg ? minor_reg + 1'b1 : minor_reg - 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            pixel_x_reg     <= px;
            pixel_y_reg     <= py;
            pixel_color_reg <= color_reg;
            visible_reg     <= ({1'b0, px} < frame_width_reg) &&
                               ({1'b0, py} < frame_height_reg);
            last_pixel_reg  <= status.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign visible     = visible_reg;
    assign last_pixel  = last_pixel_reg;

`ifndef ASSERT_OFF
    a_err_upper: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg <= dmaj_s)
        else $error("error term above major delta");

    a_err_lower: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg >= -dmaj_s)
        else $error("error term below negative major delta");

    a_valid_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.step))
        else $error("output item appeared without a step");
`endif

endmodule

`default_nettype wire
